// ===== src/polyline_tangent_azimuth_core_assert.svh =====
// Assertion macros for the block that checks itself.
`ifndef POLYLINE_TANGENT_AZIMUTH_CORE_ASSERT_SVH
`define POLYLINE_TANGENT_AZIMUTH_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while reset is active.
`define PTAZ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptaz: same-cycle check failed");

// Next-cycle implication, checked on clk, off while reset is active.
`define PTAZ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptaz: next-cycle check failed");

`endif

// ===== src/ptaz_pkg.sv =====
`timescale 1ns / 1ps
package ptaz_pkg;

	localparam int COORD_BITS      = 32;
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int TOL_BITS        = 16;
	localparam int AZ_BITS         = 15;
	localparam int INT_FRAC        = 16;

	// digit-serial difference
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int DIG_BITS  = 4;
	localparam int DIG_COUNT = (DIFF_BITS + DIG_BITS - 1) / DIG_BITS;
	localparam int SER_BITS  = DIG_COUNT * DIG_BITS;
	localparam int DIG_CNT_W = $clog2(DIG_COUNT);

	// CORDIC datapath: gain and the diagonal need two bits over the magnitude
	localparam int CRD_BITS  = DIFF_BITS + 2;
	localparam int STEP_W    = $clog2(CORDIC_STEPS);
	localparam int TAB_IDX_W = 5;
	localparam int ZC_BITS   = INT_FRAC + 7;
	localparam int Z_BITS    = ZC_BITS + 1;

	// bearing assembly and rounding
	localparam int ANG_BITS  = INT_FRAC + 9;
	localparam int RND_SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
	localparam int R_BITS    = ANG_BITS - RND_SHIFT;

	localparam logic [ZC_BITS-1:0]  Z_RIGHT  = ZC_BITS'(90 * (1 << INT_FRAC));
	localparam logic [ANG_BITS-1:0] ANG_90   = ANG_BITS'(90 * (1 << INT_FRAC));
	localparam logic [ANG_BITS-1:0] ANG_270  = ANG_BITS'(270 * (1 << INT_FRAC));
	localparam logic [ANG_BITS-1:0] ANG_HALF = ANG_BITS'(1 << (RND_SHIFT - 1));
	localparam logic [R_BITS-1:0]   R_FULL   = R_BITS'(360 * (1 << ANGLE_FRAC_BITS));

	localparam logic [AZ_BITS-1:0] AZ_0   = '0;
	localparam logic [AZ_BITS-1:0] AZ_90  = AZ_BITS'(90 * (1 << ANGLE_FRAC_BITS));
	localparam logic [AZ_BITS-1:0] AZ_180 = AZ_BITS'(180 * (1 << ANGLE_FRAC_BITS));
	localparam logic [AZ_BITS-1:0] AZ_270 = AZ_BITS'(270 * (1 << ANGLE_FRAC_BITS));

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [ZC_BITS-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
		unique case (idx)
			5'd0:    atan_q16 = ZC_BITS'(2949120);
			5'd1:    atan_q16 = ZC_BITS'(1740967);
			5'd2:    atan_q16 = ZC_BITS'(919879);
			5'd3:    atan_q16 = ZC_BITS'(466945);
			5'd4:    atan_q16 = ZC_BITS'(234379);
			5'd5:    atan_q16 = ZC_BITS'(117304);
			5'd6:    atan_q16 = ZC_BITS'(58666);
			5'd7:    atan_q16 = ZC_BITS'(29335);
			5'd8:    atan_q16 = ZC_BITS'(14668);
			5'd9:    atan_q16 = ZC_BITS'(7334);
			5'd10:   atan_q16 = ZC_BITS'(3667);
			5'd11:   atan_q16 = ZC_BITS'(1833);
			5'd12:   atan_q16 = ZC_BITS'(917);
			5'd13:   atan_q16 = ZC_BITS'(458);
			5'd14:   atan_q16 = ZC_BITS'(229);
			5'd15:   atan_q16 = ZC_BITS'(115);
			5'd16:   atan_q16 = ZC_BITS'(57);
			5'd17:   atan_q16 = ZC_BITS'(29);
			5'd18:   atan_q16 = ZC_BITS'(14);
			5'd19:   atan_q16 = ZC_BITS'(7);
			5'd20:   atan_q16 = ZC_BITS'(4);
			5'd21:   atan_q16 = ZC_BITS'(2);
			5'd22:   atan_q16 = ZC_BITS'(1);
			default: atan_q16 = '0;
		endcase
	endfunction

endpackage

// ===== src/ptaz_diff.sv =====
`timescale 1ns / 1ps
module ptaz_diff (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ptaz_pkg::COORD_BITS-1:0]    min_x,
	input  logic [ptaz_pkg::COORD_BITS-1:0]    min_y,
	input  logic [ptaz_pkg::COORD_BITS-1:0]    sub_x,
	input  logic [ptaz_pkg::COORD_BITS-1:0]    sub_y,
	output logic                               done,
	output logic [ptaz_pkg::DIFF_BITS-1:0]     dx,
	output logic [ptaz_pkg::DIFF_BITS-1:0]     dy
);

	localparam int SB = ptaz_pkg::SER_BITS;
	localparam int DB = ptaz_pkg::DIG_BITS;
	localparam int CB = ptaz_pkg::COORD_BITS;

	logic [SB-1:0] sh_x_q, sh_y_q, sb_x_q, sb_y_q;
	logic          cy_x_q, cy_y_q;
	logic [ptaz_pkg::DIG_CNT_W-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DB:0]   dig_x, dig_y;

	function automatic logic [DB:0] dig_sub(input logic [DB-1:0] a, input logic [DB-1:0] b,
		input logic cin);
		dig_sub = {1'b0, a} + {1'b0, ~b} + {{DB{1'b0}}, cin};
	endfunction

	assign dig_x = dig_sub(sh_x_q[DB-1:0], sb_x_q[DB-1:0], cy_x_q);
	assign dig_y = dig_sub(sh_y_q[DB-1:0], sb_y_q[DB-1:0], cy_y_q);

	// difference digits enter at the top as the minuend leaves at the bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_x_q <= '0;
			sh_y_q <= '0;
			sb_x_q <= '0;
			sb_y_q <= '0;
			cy_x_q <= 1'b1;
			cy_y_q <= 1'b1;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sh_x_q <= {{(SB - CB){min_x[CB-1]}}, min_x};
				sh_y_q <= {{(SB - CB){min_y[CB-1]}}, min_y};
				sb_x_q <= {{(SB - CB){sub_x[CB-1]}}, sub_x};
				sb_y_q <= {{(SB - CB){sub_y[CB-1]}}, sub_y};
				cy_x_q <= 1'b1;
				cy_y_q <= 1'b1;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				sh_x_q <= {dig_x[DB-1:0], sh_x_q[SB-1:DB]};
				sh_y_q <= {dig_y[DB-1:0], sh_y_q[SB-1:DB]};
				sb_x_q <= sb_x_q >> DB;
				sb_y_q <= sb_y_q >> DB;
				cy_x_q <= dig_x[DB];
				cy_y_q <= dig_y[DB];
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == ptaz_pkg::DIG_CNT_W'(ptaz_pkg::DIG_COUNT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign dx   = sh_x_q[ptaz_pkg::DIFF_BITS-1:0];
	assign dy   = sh_y_q[ptaz_pkg::DIFF_BITS-1:0];

endmodule

// ===== src/ptaz_cordic.sv =====
`timescale 1ns / 1ps
module ptaz_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ptaz_pkg::DIFF_BITS-1:0]    ax,
	input  logic [ptaz_pkg::DIFF_BITS-1:0]    ay,
	output logic                              done,
	output logic [ptaz_pkg::ZC_BITS-1:0]      z_out
);

	localparam int CW = ptaz_pkg::CRD_BITS;
	localparam int ZW = ptaz_pkg::Z_BITS;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, ang_s;
	logic [ptaz_pkg::STEP_W-1:0]  step_q;
	logic                 busy_q, clamp_q, done_q;
	logic [ptaz_pkg::ZC_BITS-1:0] zc_q;

	assign xs    = x_q >>> step_q;
	assign ys    = y_q >>> step_q;
	assign ang_s = signed'({1'b0,
		ptaz_pkg::atan_q16(ptaz_pkg::TAB_IDX_W'(step_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			step_q  <= '0;
			busy_q  <= 1'b0;
			clamp_q <= 1'b0;
			done_q  <= 1'b0;
			zc_q    <= '0;
		end else begin
			done_q  <= 1'b0;
			clamp_q <= 1'b0;
			if (start) begin
				x_q    <= signed'({2'b00, ax});
				y_q    <= signed'({2'b00, ay});
				z_q    <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// rotate toward the x axis from whichever side y sits
				if (!y_q[CW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ang_s;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ang_s;
				end
				step_q <= step_q + 1'b1;
				if (step_q == ptaz_pkg::STEP_W'(ptaz_pkg::CORDIC_STEPS - 1)) begin
					busy_q  <= 1'b0;
					clamp_q <= 1'b1;
				end
			end else if (clamp_q) begin
				priority if (z_q[ZW-1])
					zc_q <= '0;
				else if (z_q[ptaz_pkg::ZC_BITS-1:0] > ptaz_pkg::Z_RIGHT)
					zc_q <= ptaz_pkg::Z_RIGHT;
				else
					zc_q <= z_q[ptaz_pkg::ZC_BITS-1:0];
				done_q <= 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign z_out = zc_q;

endmodule

// ===== src/polyline_tangent_azimuth_core.sv =====
`timescale 1ns / 1ps
// Tangent bearing along a streamed polyline, in 1/64 degree clockwise from north. A point is
// taken only while the core is idle; each bearing runs a 9-digit serial subtract (4 bits a
// cycle, both coordinates at once), a magnitude and tolerance check, then 16 CORDIC steps on
// one shared add/shift unit plus a clamp, a quadrant and a rounding step; the rotation is
// skipped when a difference falls inside the tolerance, and the next point is taken in the
// cycle after the word is loaded. A point gives one bearing, the last point of a line of two
// or more points two, the first point of a longer line none, and a lone point one flagged
// word. The output register lets the next point in while a word waits.
`include "polyline_tangent_azimuth_core_assert.svh"
module polyline_tangent_azimuth_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [ptaz_pkg::TOL_BITS-1:0]            cfg_wr_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [ptaz_pkg::COORD_BITS-1:0]   x_coord,
	input  logic signed [ptaz_pkg::COORD_BITS-1:0]   y_coord,
	input  logic                                     last_point,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [ptaz_pkg::AZ_BITS-1:0]             azimuth,
	output logic                                     degenerate,
	output logic                                     last_result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_ABS   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_ROT   = 3'd4;
	localparam logic [2:0] ST_RND   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	localparam logic [1:0] PS_ZERO = 2'd0;
	localparam logic [1:0] PS_ONE  = 2'd1;
	localparam logic [1:0] PS_TWO  = 2'd2;

	localparam int CB = ptaz_pkg::COORD_BITS;
	localparam int DB = ptaz_pkg::DIFF_BITS;
	localparam int AB = ptaz_pkg::ANG_BITS;

	logic [2:0]    state_q;
	logic [1:0]    ps_q;
	logic [ptaz_pkg::TOL_BITS-1:0] tol_q;
	logic [CB-1:0] x_q, y_q, older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic          last_q, use_newer_q, job_q, deg_q;
	logic          diff_start_q, crd_start_q;
	logic [DB-1:0] ax_q, ay_q;
	logic          dx_pos_q, dy_pos_q;
	logic [AB-1:0] ang_q;
	logic [ptaz_pkg::AZ_BITS-1:0] res_az_q;
	logic          out_valid_q, out_deg_q, out_last_q;
	logic [ptaz_pkg::AZ_BITS-1:0] out_az_q;

	logic          diff_done, crd_done;
	logic [DB-1:0] diff_dx, diff_dy, ax_next, ay_next, tol_ext;
	logic [ptaz_pkg::ZC_BITS-1:0] crd_z;
	logic [AB-1:0] z_ext, ang_next, rsum;
	logic [ptaz_pkg::R_BITS-1:0] r_raw, r_wrap;
	logic          emit_fire;

	ptaz_diff u_diff (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (diff_start_q),
		.min_x  (x_q),
		.min_y  (y_q),
		.sub_x  (use_newer_q ? newer_x_q : older_x_q),
		.sub_y  (use_newer_q ? newer_y_q : older_y_q),
		.done   (diff_done),
		.dx     (diff_dx),
		.dy     (diff_dy)
	);

	ptaz_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crd_start_q),
		.ax     (ax_q),
		.ay     (ay_q),
		.done   (crd_done),
		.z_out  (crd_z)
	);

	assign ax_next = diff_dx[DB-1] ? (~diff_dx + 1'b1) : diff_dx;
	assign ay_next = diff_dy[DB-1] ? (~diff_dy + 1'b1) : diff_dy;
	assign tol_ext = DB'(tol_q);

	// bearing from the first-quadrant angle
	assign z_ext = AB'(crd_z);
	always_comb begin
		unique case ({dx_pos_q, dy_pos_q})
			2'b11:   ang_next = ptaz_pkg::ANG_90 - z_ext;
			2'b10:   ang_next = ptaz_pkg::ANG_90 + z_ext;
			2'b01:   ang_next = ptaz_pkg::ANG_270 + z_ext;
			default: ang_next = ptaz_pkg::ANG_270 - z_ext;
		endcase
	end

	assign rsum   = ang_q + ptaz_pkg::ANG_HALF;
	assign r_raw  = rsum[AB-1:ptaz_pkg::RND_SHIFT];
	assign r_wrap = (r_raw >= ptaz_pkg::R_FULL) ? (r_raw - ptaz_pkg::R_FULL) : r_raw;

	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ptaz_pkg::TOL_BITS'(1);
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ps_q         <= PS_ZERO;
			x_q          <= '0;
			y_q          <= '0;
			older_x_q    <= '0;
			older_y_q    <= '0;
			newer_x_q    <= '0;
			newer_y_q    <= '0;
			last_q       <= 1'b0;
			use_newer_q  <= 1'b0;
			job_q        <= 1'b0;
			deg_q        <= 1'b0;
			diff_start_q <= 1'b0;
			crd_start_q  <= 1'b0;
			ax_q         <= '0;
			ay_q         <= '0;
			dx_pos_q     <= 1'b0;
			dy_pos_q     <= 1'b0;
			ang_q        <= '0;
			res_az_q     <= '0;
			out_valid_q  <= 1'b0;
			out_az_q     <= '0;
			out_deg_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			diff_start_q <= 1'b0;
			crd_start_q  <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: if (in_valid) begin
					x_q         <= x_coord;
					y_q         <= y_coord;
					last_q      <= last_point;
					job_q       <= 1'b0;
					use_newer_q <= (ps_q == PS_ONE);
					if (ps_q == PS_ZERO) begin
						if (last_point) begin
							// lone point: flagged word, no difference
							deg_q    <= 1'b1;
							res_az_q <= ptaz_pkg::AZ_0;
							state_q  <= ST_EMIT;
						end else begin
							newer_x_q <= x_coord;
							newer_y_q <= y_coord;
							ps_q      <= PS_ONE;
						end
					end else begin
						diff_start_q <= 1'b1;
						state_q      <= ST_DIFF;
					end
				end
				ST_DIFF: if (diff_done) begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					ax_q     <= ax_next;
					ay_q     <= ay_next;
					dx_pos_q <= !diff_dx[DB-1] && (diff_dx != '0);
					dy_pos_q <= !diff_dy[DB-1] && (diff_dy != '0);
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					priority if (ay_q <= tol_ext) begin
						res_az_q <= dx_pos_q ? ptaz_pkg::AZ_90 : ptaz_pkg::AZ_270;
						state_q  <= ST_EMIT;
					end else if (ax_q <= tol_ext) begin
						res_az_q <= dy_pos_q ? ptaz_pkg::AZ_0 : ptaz_pkg::AZ_180;
						state_q  <= ST_EMIT;
					end else begin
						crd_start_q <= 1'b1;
						state_q     <= ST_ROT;
					end
				end
				ST_ROT: if (crd_done) begin
					ang_q   <= ang_next;
					state_q <= ST_RND;
				end
				ST_RND: begin
					res_az_q <= ptaz_pkg::AZ_BITS'(r_wrap);
					state_q  <= ST_EMIT;
				end
				ST_EMIT: if (emit_fire) begin
					out_valid_q <= 1'b1;
					out_az_q    <= res_az_q;
					out_deg_q   <= deg_q;
					out_last_q  <= deg_q || job_q;
					priority if (deg_q) begin
						deg_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else if (!job_q && last_q) begin
						// closing point: backward difference, reused when the line has two points
						job_q <= 1'b1;
						if (ps_q == PS_TWO) begin
							use_newer_q  <= 1'b1;
							diff_start_q <= 1'b1;
							state_q      <= ST_DIFF;
						end
					end else begin
						if (last_q) begin
							ps_q <= PS_ZERO;
						end else begin
							older_x_q <= newer_x_q;
							older_y_q <= newer_y_q;
							newer_x_q <= x_q;
							newer_y_q <= y_q;
							ps_q      <= PS_TWO;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign azimuth     = out_az_q;
	assign degenerate  = out_deg_q;
	assign last_result = out_last_q;

	`PTAZ_ASSERT_NOW(a_deg_word, out_valid && degenerate, last_result && (azimuth == ptaz_pkg::AZ_0))
	`PTAZ_ASSERT_NOW(a_diff_done_state, diff_done, state_q == ST_DIFF)
	`PTAZ_ASSERT_NOW(a_crd_done_state, crd_done, state_q == ST_ROT)
	`PTAZ_ASSERT_NEXT(a_emit_loads, emit_fire, out_valid && (ps_q != 2'd3))

endmodule
